[rtl/ckfr_pkg.sv]
// ckfr_pkg: constants, state encoding and controller/datapath bundles
// for the checksum frame receiver; no dependencies
`default_nettype none

package ckfr_pkg;

   localparam int BYTE_W           = 8;
   localparam int LEN_W            = 6;
   localparam int MAX_DATA_DEFAULT = 32;

   localparam logic [BYTE_W-1:0] START_MARK = 8'hAA;
   localparam logic [BYTE_W-1:0] STOP_MARK  = 8'h55;
   localparam logic [BYTE_W-1:0] OVERHEAD   = 8'd5;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_LENGTH,
      ST_COMMAND,
      ST_DATA,
      ST_CHECKSUM,
      ST_STOP,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_length;
      logic load_command;
      logic write_data;
      logic load_checksum;
      logic start_read;
      logic next_read;
   } dp_cmd_type;

   typedef struct packed {
      logic is_start;
      logic length_bad;
      logic no_data;
      logic data_done;
      logic frame_good;
      logic read_last;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/ckfr_if.sv]
// ckfr_req_if / ckfr_rsp_if: valid/ready channels of the frame receiver
// depends on ckfr_pkg
`default_nettype none

interface ckfr_req_if;
   logic                        valid;
   logic                        ready;
   logic [ckfr_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ckfr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ckfr_pkg::BYTE_W-1:0] command;
   logic [ckfr_pkg::LEN_W-1:0]  data_length;
   logic [ckfr_pkg::BYTE_W-1:0] data_byte;
   logic                        data_present;
   logic                        last;

   modport source (output valid, output command, output data_length, output data_byte,
                   output data_present, output last, input ready);
   modport sink   (input valid, input command, input data_length, input data_byte,
                   input data_present, input last, output ready);
endinterface

`default_nettype wire

[rtl/ckfr_datapath.sv]
// ckfr_datapath: length, command, checksum registers, data buffer and
// result payload; depends on ckfr_pkg
`default_nettype none

module ckfr_datapath #(
   parameter int MAX_DATA = ckfr_pkg::MAX_DATA_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ckfr_pkg::dp_cmd_type        cmd,
   input  wire logic [ckfr_pkg::BYTE_W-1:0] rx_byte,
   output ckfr_pkg::dp_status_type          status,
   output logic [ckfr_pkg::BYTE_W-1:0]      command,
   output logic [ckfr_pkg::LEN_W-1:0]       data_length,
   output logic [ckfr_pkg::BYTE_W-1:0]      data_byte,
   output logic                             data_present,
   output logic                             last
);

   localparam int IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
   localparam logic [ckfr_pkg::BYTE_W-1:0] MAX_LEN =
      ckfr_pkg::BYTE_W'(MAX_DATA + 5);

   logic [ckfr_pkg::BYTE_W-1:0] mem_ff [MAX_DATA];
   logic [ckfr_pkg::BYTE_W-1:0] rd_data_ff;

   logic [ckfr_pkg::LEN_W-1:0]  ndata_ff, ndata_in;
   logic [ckfr_pkg::BYTE_W-1:0] command_ff, command_in;
   logic [ckfr_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [ckfr_pkg::BYTE_W-1:0] csum_ff, csum_in;
   logic [ckfr_pkg::LEN_W-1:0]  wr_cnt_ff, wr_cnt_in;
   logic [ckfr_pkg::LEN_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic                        empty_ff, empty_in;
   logic [ckfr_pkg::LEN_W-1:0]  ndata_last;

   assign ndata_last = ndata_ff - ckfr_pkg::LEN_W'(1);

   // data buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write_data) begin
         mem_ff[wr_cnt_ff[IDX_W-1:0]] <= rx_byte;
      end
      rd_data_ff <= mem_ff[rd_cnt_ff[IDX_W-1:0]];
   end

   always_comb begin
      ndata_in   = ndata_ff;
      command_in = command_ff;
      sum_in     = sum_ff;
      csum_in    = csum_ff;
      wr_cnt_in  = wr_cnt_ff;
      rd_cnt_in  = rd_cnt_ff;
      empty_in   = empty_ff;
      if (cmd.load_length) begin
         ndata_in  = ckfr_pkg::LEN_W'(rx_byte - ckfr_pkg::OVERHEAD);
         sum_in    = rx_byte;
         wr_cnt_in = '0;
      end
      if (cmd.load_command) begin
         command_in = rx_byte;
         sum_in     = sum_ff + rx_byte;
      end
      if (cmd.write_data) begin
         sum_in    = sum_ff + rx_byte;
         wr_cnt_in = wr_cnt_ff + ckfr_pkg::LEN_W'(1);
      end
      if (cmd.load_checksum) begin
         csum_in = rx_byte;
      end
      if (cmd.start_read) begin
         rd_cnt_in = '0;
         empty_in  = (ndata_ff == '0);
      end
      if (cmd.next_read) begin
         rd_cnt_in = rd_cnt_ff + ckfr_pkg::LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ndata_ff  <= '0;
         wr_cnt_ff <= '0;
         rd_cnt_ff <= '0;
         empty_ff  <= 1'b0;
      end else begin
         ndata_ff  <= ndata_in;
         wr_cnt_ff <= wr_cnt_in;
         rd_cnt_ff <= rd_cnt_in;
         empty_ff  <= empty_in;
      end
      command_ff <= command_in;
      sum_ff     <= sum_in;
      csum_ff    <= csum_in;
   end

   assign status.is_start   = (rx_byte == ckfr_pkg::START_MARK);
   assign status.length_bad = (rx_byte < ckfr_pkg::OVERHEAD) || (rx_byte > MAX_LEN);
   assign status.no_data    = (ndata_ff == '0);
   assign status.data_done  = (wr_cnt_ff == ndata_last);
   assign status.frame_good = (rx_byte == ckfr_pkg::STOP_MARK) && (csum_ff == sum_ff);
   assign status.read_last  = last;

   assign command      = command_ff;
   assign data_length  = ndata_ff;
   assign data_present = !empty_ff;
   assign data_byte    = empty_ff ? '0 : rd_data_ff;
   assign last         = empty_ff || (rd_cnt_ff == ndata_last);

endmodule

`default_nettype wire

[rtl/ckfr_controller.sv]
// ckfr_controller: frame parsing and result run state machine
// depends on ckfr_pkg
`default_nettype none

module ckfr_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire ckfr_pkg::dp_status_type status,
   output ckfr_pkg::dp_cmd_type         cmd
);

   ckfr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ckfr_pkg::ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   // ready is high in every receiving state, so valid alone marks a taken byte there
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ckfr_pkg::ST_HUNT: begin
            req_ready = 1'b1;
            if (req_valid && status.is_start) begin
               state_in = ckfr_pkg::ST_LENGTH;
            end
         end
         ckfr_pkg::ST_LENGTH: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.length_bad) begin
                  state_in = ckfr_pkg::ST_HUNT;
               end else begin
                  cmd.load_length = 1'b1;
                  state_in        = ckfr_pkg::ST_COMMAND;
               end
            end
         end
         ckfr_pkg::ST_COMMAND: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_command = 1'b1;
               state_in = status.no_data ? ckfr_pkg::ST_CHECKSUM : ckfr_pkg::ST_DATA;
            end
         end
         ckfr_pkg::ST_DATA: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.write_data = 1'b1;
               if (status.data_done) begin
                  state_in = ckfr_pkg::ST_CHECKSUM;
               end
            end
         end
         ckfr_pkg::ST_CHECKSUM: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_checksum = 1'b1;
               state_in          = ckfr_pkg::ST_STOP;
            end
         end
         ckfr_pkg::ST_STOP: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.frame_good) begin
                  cmd.start_read = 1'b1;
                  state_in = status.no_data ? ckfr_pkg::ST_EMIT : ckfr_pkg::ST_READ;
               end else begin
                  state_in = ckfr_pkg::ST_HUNT;
               end
            end
         end
         ckfr_pkg::ST_READ: begin
            state_in = ckfr_pkg::ST_EMIT;
         end
         ckfr_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.read_last) begin
                  state_in = ckfr_pkg::ST_HUNT;
               end else begin
                  cmd.next_read = 1'b1;
                  state_in      = ckfr_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = ckfr_pkg::ST_HUNT;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/checksum_frame_receiver.sv]
// checksum_frame_receiver: top level, controller plus datapath
// depends on ckfr_pkg, ckfr_if, ckfr_controller, ckfr_datapath
//
// Receives one serial byte per word on req_ch and assembles frames of the form
// 0xAA, total length L, command, L-5 data bytes, checksum, 0x55. A byte is taken
// every cycle while a frame is being received. After the stop byte of a good
// frame the run of results leaves on rsp_ch, each word a data buffer read and then
// the result word held until rsp_ready, or one word for a frame without data; no
// byte is taken until the last word of the run has been delivered. Bad length,
// checksum or stop bytes drop the frame with no result. No clearing after reset.
`default_nettype none

module checksum_frame_receiver #(
   parameter int MAX_DATA = ckfr_pkg::MAX_DATA_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ckfr_req_if.sink    req_ch,
   ckfr_rsp_if.source  rsp_ch
);

   ckfr_pkg::dp_cmd_type    dp_cmd;
   ckfr_pkg::dp_status_type dp_status;

   ckfr_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   ckfr_datapath #(
      .MAX_DATA (MAX_DATA)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .rx_byte      (req_ch.rx_byte),
      .status       (dp_status),
      .command      (rsp_ch.command),
      .data_length  (rsp_ch.data_length),
      .data_byte    (rsp_ch.data_byte),
      .data_present (rsp_ch.data_present),
      .last         (rsp_ch.last)
   );

endmodule

`default_nettype wire

[rtl/ckfr_checker.sv]
// ckfr_checker: port-level assertions for checksum_frame_receiver
// depends on ckfr_pkg; bound to the top level below
`default_nettype none

module ckfr_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [ckfr_pkg::BYTE_W-1:0] command,
   input wire logic [ckfr_pkg::LEN_W-1:0]  data_length,
   input wire logic [ckfr_pkg::BYTE_W-1:0] data_byte,
   input wire logic                        data_present,
   input wire logic                        last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(command) && $stable(data_length)
                                  && $stable(data_byte) && $stable(last))
      else $error("rsp word changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("byte taken during result run");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !data_present |-> last && (data_length == '0) && (data_byte == '0))
      else $error("bad frame without data");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready && !$isunknown(req_valid) || !rsp_valid)
      else $error("result after reset");

endmodule

bind checksum_frame_receiver ckfr_checker u_ckfr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .command      (rsp_ch.command),
   .data_length  (rsp_ch.data_length),
   .data_byte    (rsp_ch.data_byte),
   .data_present (rsp_ch.data_present),
   .last         (rsp_ch.last)
);

`default_nettype wire

[dv/ckfr_frame_checker.sv]
// ckfr_frame_checker: watches both channels of the frame receiver, predicts the
// result words of every accepted byte and compares them in order
// depends on ckfr_pkg and ckfr_if
`timescale 1ns / 100ps

module ckfr_frame_checker (
   input  wire logic clock,
   input  wire logic reset,
   ckfr_req_if       req_ch,
   ckfr_rsp_if       rsp_ch,
   output int        fail_count,
   output int        pending
);
   import ckfr_pkg::*;

   localparam int STORE_DEPTH = MAX_DATA_DEFAULT;
   localparam int MAX_LENGTH  = STORE_DEPTH + int'(OVERHEAD);
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] command;
      logic [LEN_W-1:0]  data_length;
      logic [BYTE_W-1:0] data_byte;
      logic              data_present;
      logic              last;
   } frame_word_t;

   frame_word_t expected_words[$];

   logic              hunting;
   int                position;
   int                frame_len;
   logic [BYTE_W-1:0] cmd_held;
   logic [BYTE_W-1:0] running_sum;
   logic [BYTE_W-1:0] cksum_held;
   logic [BYTE_W-1:0] payload [STORE_DEPTH];

   int mismatches = 0;
   int waiting    = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   task automatic drop_to_hunt();
      hunting     = 1'b1;
      position    = 0;
      frame_len   = 0;
      running_sum = '0;
   endtask

   task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b);
      int ndata;
      logic good;
      if (hunting) begin
         if (b == START_MARK) begin
            hunting     = 1'b0;
            position    = 0;
            running_sum = '0;
         end
      end else begin
         position++;
         ndata = frame_len - int'(OVERHEAD);
         if (position == 1) begin
            if (b < OVERHEAD || int'(b) > MAX_LENGTH) begin
               drop_to_hunt();
            end else begin
               frame_len   = int'(b);
               running_sum = running_sum + b;
            end
         end else if (position == 2) begin
            cmd_held    = b;
            running_sum = running_sum + b;
         end else if (position < 3 + ndata) begin
            payload[position - 3] = b;
            running_sum = running_sum + b;
         end else if (position == 3 + ndata) begin
            cksum_held = b;
         end else begin
            // stop byte: decide and queue the run
            good = (b == STOP_MARK) && (cksum_held == running_sum);
            drop_to_hunt();
            if (good && ndata == 0) begin
               expected_words.push_back('{cmd_held, '0, '0, 1'b0, 1'b1});
            end else if (good) begin
               for (int k = 0; k < ndata; k++)
                  expected_words.push_back('{cmd_held, LEN_W'(ndata), payload[k], 1'b1,
                                            k == ndata - 1});
            end
         end
      end
   endtask

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%t mismatch: %s", $realtime, msg);
   endtask

   task automatic check_word(input frame_word_t got);
      frame_word_t want;
      if (expected_words.size() == 0) begin
         note_mismatch($sformatf("word with none expected: cmd=%h len=%0d data=%h pres=%b last=%b",
                                 got.command, got.data_length, got.data_byte,
                                 got.data_present, got.last));
      end else begin
         want = expected_words.pop_front();
         if (got.command !== want.command || got.data_length !== want.data_length ||
             got.data_byte !== want.data_byte || got.data_present !== want.data_present ||
             got.last !== want.last)
            note_mismatch($sformatf({"expected cmd=%h len=%0d data=%h pres=%b last=%b, ",
                                     "got cmd=%h len=%0d data=%h pres=%b last=%b"},
                                    want.command, want.data_length, want.data_byte,
                                    want.data_present, want.last,
                                    got.command, got.data_length, got.data_byte,
                                    got.data_present, got.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         drop_to_hunt();
         cmd_held   = '0;
         cksum_held = '0;
         expected_words.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            absorb_rx_byte(req_ch.rx_byte);
         if (rsp_ch.valid && rsp_ch.ready)
            check_word('{rsp_ch.command, rsp_ch.data_length, rsp_ch.data_byte,
                         rsp_ch.data_present, rsp_ch.last});
      end
      waiting = expected_words.size();
   end

endmodule

[dv/tb_checksum_frame_receiver.sv]
// tb_checksum_frame_receiver: drives serial bytes and frames into the receiver,
// paces the result side and gives the verdict
// depends on ckfr_pkg, ckfr_if, checksum_frame_receiver and ckfr_frame_checker
`timescale 1ns / 100ps

module tb_checksum_frame_receiver;
   import ckfr_pkg::*;

   localparam int PERIOD          = 20;
   localparam int RESET_CYCLES    = 10;
   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 20;
   localparam int RANDOM_ITEMS    = 180;
   localparam int CALM_ITEMS      = 150;
   localparam int MAX_DATA        = MAX_DATA_DEFAULT;
   localparam int MAX_LENGTH      = MAX_DATA + int'(OVERHEAD);

   typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_STOP, FR_BAD_LENGTH} frame_flaw_t;

   logic clock = 1'b0;
   logic reset;
   logic calm         = 1'b0;
   logic hold_off_req = 1'b0;
   int   frame_items  = 0;
   int   idle_cycles  = 0;
   int   fail_count;
   int   pending;

   ckfr_req_if req_ch();
   ckfr_rsp_if rsp_ch();

   checksum_frame_receiver u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ckfr_frame_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #(PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** checksum_frame_receiver: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side pacing, with one long hold-off to back up the input
   initial begin : rsp_pacing
      logic hold_off_done;
      hold_off_done = 1'b0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 19)) @(negedge clock);
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame(input int ndata, input logic [BYTE_W-1:0] cmd,
                             input frame_flaw_t flaw);
      logic [BYTE_W-1:0] len;
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      len = BYTE_W'(ndata) + OVERHEAD;
      if (flaw == FR_BAD_LENGTH)
         len = $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, int'(OVERHEAD) - 1))
                                    : BYTE_W'($urandom_range(MAX_LENGTH + 1, 255));
      send_byte(START_MARK);
      send_byte(len);
      frame_items += 2;
      if (flaw != FR_BAD_LENGTH) begin
         sum = len + cmd;
         send_byte(cmd);
         for (int k = 0; k < ndata; k++) begin
            b = ($urandom_range(0, 7) == 0) ? START_MARK : BYTE_W'($urandom);
            sum = sum + b;
            send_byte(b);
         end
         if (flaw == FR_BAD_SUM)
            sum = sum + BYTE_W'($urandom_range(1, 255));
         send_byte(sum);
         send_byte(flaw == FR_BAD_STOP ? STOP_MARK ^ BYTE_W'($urandom_range(1, 255))
                                       : STOP_MARK);
         frame_items += ndata + 3;
      end
   endtask

   initial begin : stimulus
      int          pick;
      int          ndata;
      frame_flaw_t flaw;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // noise while hunting, shortest frames, bad lengths, start byte as data
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(0, 8'h00, FR_GOOD);
      send_byte(START_MARK);
      send_byte(OVERHEAD - 8'd1);
      send_byte(START_MARK);
      send_byte(BYTE_W'(MAX_LENGTH + 1));
      send_byte(START_MARK);
      send_byte(OVERHEAD + 8'd1);
      send_byte(8'hFF);
      send_byte(START_MARK);
      send_byte(OVERHEAD + 8'd1 + 8'hFF + START_MARK);
      send_byte(STOP_MARK);
      send_frame(0, 8'hFF, FR_BAD_SUM);
      send_frame(1, 8'h5A, FR_BAD_STOP);

      // full-size frame while the result side holds off
      frame_items  = 0;
      hold_off_req = 1'b1;
      send_frame(MAX_DATA, BYTE_W'($urandom), FR_GOOD);
      while (frame_items < RANDOM_ITEMS) begin
         if (frame_items >= CALM_ITEMS)
            calm = 1'b1;
         pick = $urandom_range(0, 9);
         if (pick == 0)
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
         ndata = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_DATA)
                                             : $urandom_range(0, 4);
         flaw = (pick <= 6) ? FR_GOOD :
                (pick == 7) ? FR_BAD_SUM :
                (pick == 8) ? FR_BAD_STOP : FR_BAD_LENGTH;
         send_frame(ndata, BYTE_W'($urandom), flaw);
      end
      req_ch.valid <= 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** checksum_frame_receiver: PASSED **");
      else
         $display("** checksum_frame_receiver: FAILED **");
      $finish;
   end

endmodule

[files.f]
rtl/ckfr_pkg.sv
rtl/ckfr_if.sv
rtl/ckfr_datapath.sv
rtl/ckfr_controller.sv
rtl/checksum_frame_receiver.sv
rtl/ckfr_checker.sv
dv/ckfr_frame_checker.sv
dv/tb_checksum_frame_receiver.sv
